// File: design/rbsi_pkg.sv
// Shared types, widths and helpers for the ray versus box slab test.
package rbsi_pkg;

   localparam int CoordW   = 32;              // Q16.16 coordinate width
   localparam int MagW     = 32;              // magnitude of a difference or a direction
   localparam int FracW    = 16;              // fraction bits appended to the dividend
   localparam int DivSteps = MagW + FracW;    // one quotient bit per divider stage
   localparam int TW       = DivSteps + 2;    // signed slab distance with headroom for sentinels
   localparam int DistW    = 31;              // result distance width
   localparam int Axes     = 3;

   localparam logic signed [TW-1:0] EntryNone = {1'b1, {(TW-1){1'b0}}};
   localparam logic signed [TW-1:0] ExitNone  = {1'b0, {(TW-1){1'b1}}};
   localparam logic signed [TW-1:0] DistMax   = {{(TW-DistW){1'b0}}, {DistW{1'b1}}};

   typedef struct packed {
      logic signed [CoordW-1:0] origin_x;
      logic signed [CoordW-1:0] origin_y;
      logic signed [CoordW-1:0] origin_z;
      logic signed [CoordW-1:0] direction_x;
      logic signed [CoordW-1:0] direction_y;
      logic signed [CoordW-1:0] direction_z;
      logic signed [CoordW-1:0] box_low_x;
      logic signed [CoordW-1:0] box_low_y;
      logic signed [CoordW-1:0] box_low_z;
      logic signed [CoordW-1:0] box_high_x;
      logic signed [CoordW-1:0] box_high_y;
      logic signed [CoordW-1:0] box_high_z;
   } req_type;

   typedef struct packed {
      logic             hit;
      logic [DistW-1:0] hit_distance;
   } rsp_type;

   // Per-item flags that ride alongside the divider lanes.
   typedef struct packed {
      logic [Axes-1:0] neg_lo;   // low-bound distance is negative
      logic [Axes-1:0] neg_hi;   // high-bound distance is negative
      logic [Axes-1:0] skip;     // zero direction: axis sets no bound
      logic            zmiss;    // zero direction with origin outside the slab
   } side_type;

   // Magnitude of a 33-bit signed value known to fit 32 bits unsigned.
   function automatic logic [MagW-1:0] mag_of(input logic signed [CoordW:0] v);
      logic signed [CoordW:0] a;
      a = v[CoordW] ? -v : v;
      return a[MagW-1:0];
   endfunction

endpackage

// File: design/rbsi_div.sv
// Pipelined restoring divider: one quotient bit per stage, Q16.16 dividend.
module rbsi_div import rbsi_pkg::*; (
   input  logic                clock,
   input  logic [MagW-1:0]     num_mag,
   input  logic [MagW-1:0]     den_mag,
   output logic [DivSteps-1:0] quot
);

   logic [MagW-1:0]     rem_ff  [DivSteps];
   logic [MagW-1:0]     num_ff  [DivSteps];
   logic [MagW-1:0]     den_ff  [DivSteps];
   logic [DivSteps-1:0] quot_ff [DivSteps];

   for (genvar i = 0; i < DivSteps; i++) begin : g_step
      logic [MagW-1:0]     rem_prev;
      logic [MagW-1:0]     num_prev;
      logic [MagW-1:0]     den_prev;
      logic [DivSteps-1:0] quot_prev;
      logic [MagW+1:0]     trial;
      logic [MagW-1:0]     rem_in;
      logic [DivSteps-1:0] quot_in;

      if (i == 0) begin : g_first
         assign rem_prev  = '0;
         assign num_prev  = num_mag;
         assign den_prev  = den_mag;
         assign quot_prev = '0;
      end else begin : g_next
         assign rem_prev  = rem_ff[i-1];
         assign num_prev  = num_ff[i-1];
         assign den_prev  = den_ff[i-1];
         assign quot_prev = quot_ff[i-1];
      end

      // dividend bits enter from the top of num; zeros follow for the fraction
      always_comb begin
         trial = {1'b0, rem_prev, num_prev[MagW-1]} - {2'b00, den_prev};
         if (!trial[MagW+1]) begin
            rem_in  = trial[MagW-1:0];
            quot_in = {quot_prev[DivSteps-2:0], 1'b1};
         end else begin
            rem_in  = {rem_prev[MagW-2:0], num_prev[MagW-1]};
            quot_in = {quot_prev[DivSteps-2:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         rem_ff[i]  <= rem_in;
         num_ff[i]  <= {num_prev[MagW-2:0], 1'b0};
         den_ff[i]  <= den_prev;
         quot_ff[i] <= quot_in;
      end
   end

   assign quot = quot_ff[DivSteps-1];

endmodule

// File: design/ray_box_slab_intersect_unit.sv
// Top level of the ray versus axis-aligned box slab intersection unit.
//
// Usage: present a ray and a box on req_payload and raise start; the beat is
// taken at any edge where start is high and busy is low. busy is high only
// while reset is asserted, so a new beat can be taken every cycle.
// Each accepted beat yields exactly one result beat on rsp_payload, marked by
// a one-cycle rsp_valid strobe; results leave in the order the beats came in.
// Pipeline stages: one input register (slab differences and magnitudes),
// 48 divider stages (one quotient bit each, six lanes in parallel), one stage
// for per-axis near/far ordering, one for the farthest entry and nearest
// exit, one output register for the hit decision and saturation.
// Throughput is one beat per cycle outside reset; the six dividers are fully pipelined.
// Reset (synchronous, active high) drops all beats in flight; no result is
// strobed for them. The receiver cannot stall, so nothing is ever held back.
// Miss beats carry hit = 0 and hit_distance = 0.
module ray_box_slab_intersect_unit import rbsi_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_payload,
   output logic    rsp_valid,
   output rsp_type rsp_payload
);

   localparam int Latency = DivSteps + 4;

   logic accept;
   assign busy   = reset;
   assign accept = start && !busy;

   // valid bits travelling with the data
   logic [Latency-1:0] valid_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= {valid_ff[Latency-2:0], accept};
      end
   end

   // ---- input stage: slab differences and magnitudes ----
   logic signed [CoordW-1:0] o   [Axes];
   logic signed [CoordW-1:0] d   [Axes];
   logic signed [CoordW-1:0] lo  [Axes];
   logic signed [CoordW-1:0] hi  [Axes];
   logic signed [CoordW:0]   dlo [Axes];
   logic signed [CoordW:0]   dhi [Axes];

   logic [MagW-1:0] nlo_in [Axes];
   logic [MagW-1:0] nhi_in [Axes];
   logic [MagW-1:0] den_in [Axes];
   logic [MagW-1:0] nlo_ff [Axes];
   logic [MagW-1:0] nhi_ff [Axes];
   logic [MagW-1:0] den_ff [Axes];
   side_type side_in;
   side_type side_ff;

   always_comb begin
      o[0]  = req_payload.origin_x;    o[1]  = req_payload.origin_y;
      o[2]  = req_payload.origin_z;
      d[0]  = req_payload.direction_x; d[1]  = req_payload.direction_y;
      d[2]  = req_payload.direction_z;
      lo[0] = req_payload.box_low_x;   lo[1] = req_payload.box_low_y;
      lo[2] = req_payload.box_low_z;
      hi[0] = req_payload.box_high_x;  hi[1] = req_payload.box_high_y;
      hi[2] = req_payload.box_high_z;
      side_in.zmiss = 1'b0;
      for (int a = 0; a < Axes; a++) begin
         dlo[a] = {lo[a][CoordW-1], lo[a]} - {o[a][CoordW-1], o[a]};
         dhi[a] = {hi[a][CoordW-1], hi[a]} - {o[a][CoordW-1], o[a]};
         nlo_in[a] = mag_of(dlo[a]);
         nhi_in[a] = mag_of(dhi[a]);
         den_in[a] = mag_of({d[a][CoordW-1], d[a]});
         side_in.neg_lo[a] = dlo[a][CoordW] ^ d[a][CoordW-1];
         side_in.neg_hi[a] = dhi[a][CoordW] ^ d[a][CoordW-1];
         side_in.skip[a]   = (d[a] == '0);
         // origin below low (lo - o > 0) or above high (hi - o < 0)
         if (side_in.skip[a] && ((dlo[a] > 0) || dhi[a][CoordW])) begin
            side_in.zmiss = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      nlo_ff  <= nlo_in;
      nhi_ff  <= nhi_in;
      den_ff  <= den_in;
      side_ff <= side_in;
   end

   // ---- divider lanes: two per axis ----
   logic [DivSteps-1:0] qlo [Axes];
   logic [DivSteps-1:0] qhi [Axes];

   for (genvar a = 0; a < Axes; a++) begin : g_axis
      rbsi_div u_div_lo (
         .clock   (clock),
         .num_mag (nlo_ff[a]),
         .den_mag (den_ff[a]),
         .quot    (qlo[a])
      );
      rbsi_div u_div_hi (
         .clock   (clock),
         .num_mag (nhi_ff[a]),
         .den_mag (den_ff[a]),
         .quot    (qhi[a])
      );
   end

   // flags ride a shift line matching the divider depth
   side_type side_dly_ff [DivSteps];
   always_ff @(posedge clock) begin
      side_dly_ff[0] <= side_ff;
      for (int s = 1; s < DivSteps; s++) begin
         side_dly_ff[s] <= side_dly_ff[s-1];
      end
   end

   side_type side_q;
   assign side_q = side_dly_ff[DivSteps-1];

   // ---- near/far per axis ----
   logic signed [TW-1:0] ta [Axes];
   logic signed [TW-1:0] tb [Axes];
   logic signed [TW-1:0] near_in [Axes];
   logic signed [TW-1:0] far_in  [Axes];
   logic signed [TW-1:0] near_ff [Axes];
   logic signed [TW-1:0] far_ff  [Axes];
   logic                 zmiss_a_ff;

   always_comb begin
      for (int a = 0; a < Axes; a++) begin
         ta[a] = side_q.neg_lo[a] ? -$signed({2'b00, qlo[a]}) : $signed({2'b00, qlo[a]});
         tb[a] = side_q.neg_hi[a] ? -$signed({2'b00, qhi[a]}) : $signed({2'b00, qhi[a]});
         if (side_q.skip[a]) begin
            near_in[a] = EntryNone;
            far_in[a]  = ExitNone;
         end else if (ta[a] < tb[a]) begin
            near_in[a] = ta[a];
            far_in[a]  = tb[a];
         end else begin
            near_in[a] = tb[a];
            far_in[a]  = ta[a];
         end
      end
   end

   always_ff @(posedge clock) begin
      near_ff    <= near_in;
      far_ff     <= far_in;
      zmiss_a_ff <= side_q.zmiss;
   end

   // ---- farthest entry, nearest exit ----
   logic signed [TW-1:0] entry01, exit01, entry_in, exit_in;
   logic signed [TW-1:0] entry_ff, exit_ff;
   logic                 zmiss_b_ff;

   always_comb begin
      entry01  = (near_ff[1] > near_ff[0]) ? near_ff[1] : near_ff[0];
      entry_in = (near_ff[2] > entry01) ? near_ff[2] : entry01;
      exit01   = (far_ff[1] < far_ff[0]) ? far_ff[1] : far_ff[0];
      exit_in  = (far_ff[2] < exit01) ? far_ff[2] : exit01;
   end

   always_ff @(posedge clock) begin
      entry_ff   <= entry_in;
      exit_ff    <= exit_in;
      zmiss_b_ff <= zmiss_a_ff;
   end

   // ---- hit decision and saturation ----
   logic                 miss;
   logic signed [TW-1:0] t_sel;
   rsp_type              rsp_in;
   rsp_type              rsp_ff;

   always_comb begin
      miss  = zmiss_b_ff || exit_ff[TW-1] || (entry_ff > exit_ff);
      // origin inside the box: entry is behind, so report the exit
      t_sel = entry_ff[TW-1] ? exit_ff : entry_ff;
      if (miss) begin
         rsp_in = '0;
      end else begin
         rsp_in.hit = 1'b1;
         rsp_in.hit_distance = (t_sel > DistMax) ? DistMax[DistW-1:0] : t_sel[DistW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid   = valid_ff[Latency-1];
   assign rsp_payload = rsp_ff;

   // ---- assertions ----
   a_latency : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(accept, Latency))
      else $error("result beat without a matching request beat");

   a_miss_zero : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_payload.hit) |-> (rsp_payload.hit_distance == '0))
      else $error("miss beat with nonzero distance");

   a_zero_axis_miss : assert property (@(posedge clock) disable iff (reset)
      (valid_ff[Latency-2] && zmiss_b_ff) |=> !rsp_payload.hit)
      else $error("zero-direction miss reported as hit");

endmodule

// File: tb/ray_box_slab_intersect_unit_tb.sv
// Self-checking testbench for the ray versus box slab intersection unit.
module ray_box_slab_intersect_unit_tb;
   import rbsi_pkg::*;

   // Scoreboard: holds the predicted results in order and checks each strobe.
   class slab_scoreboard;
      rsp_type pending[$];
      int      mismatches;
      int      checked;
      int      hits;

      // Signed Q16.16 quotient, truncated toward zero, on 64-bit values.
      function automatic longint q16_div(longint num, longint den);
         longint unsigned an, ad, q;
         an = num < 0 ? -num : num;
         ad = den < 0 ? -den : den;
         q = (an * 64'd65536) / ad;
         return ((num < 0) != (den < 0)) ? -longint'(q) : longint'(q);
      endfunction

      function automatic rsp_type predict_hit(req_type r);
         longint o[3], d[3], lo[3], hi[3];
         longint entry_t, exit_t, ta, tb, t;
         bit miss;
         rsp_type res;
         o  = '{r.origin_x, r.origin_y, r.origin_z};
         d  = '{r.direction_x, r.direction_y, r.direction_z};
         lo = '{r.box_low_x, r.box_low_y, r.box_low_z};
         hi = '{r.box_high_x, r.box_high_y, r.box_high_z};
         entry_t = 64'sh8000_0000_0000_0000;
         exit_t  = 64'sh7FFF_FFFF_FFFF_FFFF;
         miss = 0;
         for (int a = 0; a < 3; a++) begin
            if (d[a] == 0) begin
               if (o[a] < lo[a] || o[a] > hi[a]) miss = 1;
            end else begin
               ta = q16_div(lo[a] - o[a], d[a]);
               tb = q16_div(hi[a] - o[a], d[a]);
               if ((ta < tb ? ta : tb) > entry_t) entry_t = ta < tb ? ta : tb;
               if ((ta < tb ? tb : ta) < exit_t) exit_t = ta < tb ? tb : ta;
            end
         end
         if (exit_t < 0 || entry_t > exit_t) miss = 1;
         res = '0;
         if (!miss) begin
            t = entry_t >= 0 ? entry_t : exit_t;
            res.hit = 1'b1;
            res.hit_distance = (t > 64'sh7FFF_FFFF) ? {DistW{1'b1}} : t[DistW-1:0];
         end
         return res;
      endfunction

      function void note_ray(req_type r);
         pending.push_back(predict_hit(r));
      endfunction

      function void check_result(rsp_type got);
         rsp_type want;
         checked++;
         if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result beat: %p", got);
            return;
         end
         want = pending.pop_front();
         if (got.hit) hits++;
         if (got.hit !== want.hit || got.hit_distance !== want.hit_distance) begin
            mismatches++;
            if (mismatches <= 10)
               $display("mismatch: expected hit=%0b dist=%h, got hit=%0b dist=%h",
                        want.hit, want.hit_distance, got.hit, got.hit_distance);
         end
      endfunction
   endclass

   localparam int Latency   = 52;
   localparam int CycleCap  = 400000;

   logic    clock, reset, start, busy, rsp_valid;
   req_type req_payload;
   rsp_type rsp_payload;
   slab_scoreboard board;
   int      cycles = 0;
   int      rays_sent;

   ray_box_slab_intersect_unit DUT (.*);

   initial begin
      clock = 0;
      forever #6 clock = ~clock;
   end

   // Results cannot be held off: every strobe is checked at its edge.
   always @(posedge clock) begin
      if (!reset && rsp_valid) board.check_result(rsp_payload);
   end

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CycleCap) begin
         $display("FAILURE");
         $finish;
      end
   end

   function automatic logic [31:0] rand_coord();
      case ($urandom_range(0, 9))
         0: return 32'h8000_0000;
         1: return 32'h7FFF_FFFF;
         2: return 32'h0;
         3, 4: return $urandom;
         default: return $signed($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000;
      endcase
   endfunction

   // A random ray and a random box, mostly with ordered corners, with occasional oddities.
   function automatic req_type rand_ray();
      req_type r;
      logic [31:0] a, b;
      r = '0;
      {r.origin_x, r.origin_y, r.origin_z} = {rand_coord(), rand_coord(), rand_coord()};
      r.direction_x = ($urandom_range(0, 7) == 0) ? 32'h0 : rand_coord();
      r.direction_y = ($urandom_range(0, 7) == 0) ? 32'h0 : rand_coord();
      r.direction_z = ($urandom_range(0, 7) == 0) ? 32'h0 : rand_coord();
      for (int k = 0; k < 3; k++) begin
         a = rand_coord();
         b = rand_coord();
         // mostly ordered corners; sometimes swapped on purpose
         if ($urandom_range(0, 9) != 0 && $signed(a) > $signed(b)) {a, b} = {b, a};
         case (k)
            0: {r.box_low_x, r.box_high_x} = {a, b};
            1: {r.box_low_y, r.box_high_y} = {a, b};
            default: {r.box_low_z, r.box_high_z} = {a, b};
         endcase
      end
      return r;
   endfunction

   // One beat: hold start until the handshake edge.
   task automatic send_ray(req_type r);
      req_payload <= r;
      start <= 1'b1;
      do @(posedge clock); while (busy);
      board.note_ray(r);
      rays_sent++;
   endtask

   task automatic idle_gap();
      int n;
      n = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 80) : $urandom_range(0, 2);
      if ($urandom_range(0, 2) == 0) n = 0;   // back-to-back runs
      if (n > 0) begin
         start <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   task automatic drain();
      start <= 1'b0;
      while (board.pending.size() != 0) @(posedge clock);
   endtask

   function automatic req_type unit_ray(logic [31:0] dx, logic [31:0] lo, logic [31:0] hi);
      req_type r;
      r = '0;
      r.direction_x = dx;
      r.box_low_x = lo; r.box_high_x = hi;
      r.box_low_y = -32'sh10000; r.box_high_y = 32'sh10000;
      r.box_low_z = -32'sh10000; r.box_high_z = 32'sh10000;
      return r;
   endfunction

   initial begin
      req_type r;
      board = new();
      rays_sent = 0;
      start = 0;
      req_payload = '0;
      reset = 1;
      repeat (3) @(posedge clock);
      reset <= 0;

      // Directed beats: plain hit ahead, origin inside, behind, parallel axes,
      // all-zero direction, swapped corners, saturation and field extremes.
      send_ray(unit_ray(32'h10000, 32'h20000, 32'h30000));
      send_ray(unit_ray(32'h10000, -32'sh20000, 32'h30000));
      send_ray(unit_ray(32'h10000, -32'sh30000, -32'sh20000));
      send_ray(unit_ray(-32'sh10000, -32'sh30000, -32'sh20000));
      send_ray(unit_ray(32'h0, -32'sh10000, 32'h10000));   // all zero, inside
      send_ray(unit_ray(32'h0, 32'h10000, 32'h20000));     // zero, outside
      send_ray(unit_ray(32'h0, 32'h0, 32'h0));             // zero, on both faces
      send_ray(unit_ray(32'h10000, 32'h30000, 32'h20000)); // swapped, nonzero dir
      send_ray(unit_ray(32'h0, 32'h10000, -32'sh10000));   // swapped, zero dir
      send_ray(unit_ray(32'h1, 32'h7FFF_FFFF, 32'h7FFF_FFFF)); // saturates
      send_ray(unit_ray(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF));
      send_ray(unit_ray(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF));
      send_ray(unit_ray(32'hFFFF_FFFF, 32'h8000_0000, 32'h8000_0000));
      r = '1; send_ray(r);
      r = '0; send_ray(r);
      for (int i = 0; i < 6; i++) begin
         r = '0;
         r.origin_x = 32'h8000_0000; r.direction_x = 32'h7FFF_FFFF;
         r.box_low_x = 32'h7FFF_FFFF; r.box_high_x = 32'h7FFF_FFFF;
         r.direction_y = i[0] ? 32'h8000_0000 : 32'h1;
         r.box_high_y = 32'h7FFF_FFFF; r.box_low_y = 32'h8000_0000;
         r.direction_z = 32'h10000 << i;
         r.box_high_z = 32'h7FFF_FFFF;
         send_ray(r);
      end

      // Hold off until the pipe is empty, then the random stream.
      drain();
      for (int i = 0; i < 1950; i++) begin
         send_ray(rand_ray());
         idle_gap();
         if (i == 900) drain();
      end
      drain();
      repeat (Latency + 8) @(posedge clock);

      $display("Ran %0d rays (%0d results, %0d hits) through directed and random boxes.",
               rays_sent, board.checked, board.hits);
      if (board.mismatches == 0 && board.pending.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
